@@ rtl/barometric_sensor_compensation_defines.svh @@
// Assertion macros for the barometric compensation block.
// Included by files that carry concurrent checks.
`ifndef BAROMETRIC_SENSOR_COMPENSATION_DEFINES_SVH
`define BAROMETRIC_SENSOR_COMPENSATION_DEFINES_SVH
`ifndef ASSERT_OFF
`define BSC_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define BSC_ASSERT_NR(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define BSC_ASSERT(label, clk, rst, prop, msg)
`define BSC_ASSERT_NR(label, clk, prop, msg)
`endif
`endif

@@ rtl/bsc_pkg.sv @@
// Shared types and constants for the barometric compensation block.
// No dependencies.
`default_nettype none
package bsc_pkg;
  localparam int unsigned RawW = 24;
  localparam int unsigned TempW = 28;
  localparam int unsigned WordW = 32;
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 64;
  localparam logic [CfgIdxW-1:0] REG_TEMP = 2'd0;
  localparam logic [CfgIdxW-1:0] REG_PA = 2'd1;
  localparam logic [CfgIdxW-1:0] REG_PB = 2'd2;
  localparam logic [CfgIdxW-1:0] REG_OSS = 2'd3;
  localparam logic KIND_TEMP = 1'b0;
  localparam logic KIND_PRESS = 1'b1;

  typedef struct packed {
    logic start;
    logic sgn;
    logic [WordW-1:0] a;
    logic [WordW-1:0] b;
  } op_req_t;

  function automatic logic [WordW-1:0] asr(input logic [WordW-1:0] v, input logic [4:0] s);
    logic signed [WordW-1:0] t;
    t = $signed(v) >>> s;
    return t;
  endfunction
  function automatic logic [WordW-1:0] sx16(input logic [15:0] w);
    return {{16{w[15]}}, w};
  endfunction
endpackage
`default_nettype wire

@@ rtl/bsc_if.sv @@
// Valid/ready channel interface with a generic payload.
// Depends on nothing.
`default_nettype none
interface bsc_if #(parameter type payload_t = logic) ();
  logic valid;
  logic ready;
  payload_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/barometric_sensor_compensation.sv @@
// A temperature word takes two ops and a pressure word eleven; each multiply or
// divide is issued, runs 32 bit-serial steps and then passes a completion check.
// A new word is not accepted until the last one is loaded into the result register:
// ready is high only in the idle state and a held result stalls the result register
// load. Synchronous reset clears coefficients, sets oversampling to 3 and clears
// the stored temperature factor.
`default_nettype none
`include "barometric_sensor_compensation_defines.svh"
module barometric_sensor_compensation (
  input wire logic clk,
  input wire logic rst,
  bsc_if.sink in_ch,
  bsc_if.source out_ch,
  bsc_if.sink cfg
);
  import bsc_pkg::*;
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001, S_ISSUE = 4'b0010, S_WAIT = 4'b0100, S_OUT = 4'b1000
  } state_t;
  state_t state;
  logic [4:0] step;
  logic [63:0] tc, pa;
  logic [31:0] pb;
  logic [1:0] oss;
  logic [31:0] tf;
  logic kind;
  logic [RawW-1:0] raw;
  logic [31:0] x1, x3, b6, sq, b3, b4, b7, p, acc;
  logic [31:0] up;
  op_req_t mreq, dreq;
  logic mbusy, dbusy;
  logic [31:0] mprod, dq;
  logic use_div;
  logic [31:0] op_a, op_b;
  logic op_sgn;
  logic out_valid;
  logic [TempW-1:0] ot;
  logic [31:0] op;
  logic okind;
  logic [31:0] res;
  logic [31:0] ft;
  logic last_step;
  logic load_out;

  bsc_mul u_mul (.clk, .rst, .req(mreq), .busy(mbusy), .prod(mprod));
  bsc_div u_div (.clk, .rst, .req(dreq), .busy(dbusy), .quot(dq));

  assign cfg.ready = 1'b1;
  assign in_ch.ready = (state == S_IDLE);
  assign up = 32'(raw) >> (4'd8 - {2'b0, oss});
  assign res = use_div ? dq : mprod;
  assign ft = x1 + dq;
  assign last_step = (kind == KIND_TEMP) ? (step != 5'd0) : (step >= 5'd10);
  assign load_out = (state == S_OUT) && (!out_valid || out_ch.ready);

  // operand select per step
  always_comb begin
    use_div = 1'b0; op_sgn = 1'b0; op_a = '0; op_b = '0;
    if (kind == KIND_TEMP) begin
      case (step)
        5'd0: begin op_a = {16'b0, raw[15:0]} - {16'b0, tc[31:16]}; op_b = {16'b0, tc[15:0]}; end
        default: begin
          use_div = 1'b1; op_sgn = 1'b1;
          op_a = sx16(tc[47:32]) << 11; op_b = x1 + sx16(tc[63:48]);
        end
      endcase
    end else begin
      case (step)
        5'd0: begin op_a = b6; op_b = b6; end
        5'd1: begin op_a = sx16(pb[31:16]); op_b = sq; end
        5'd2: begin op_a = sx16(pa[31:16]); op_b = b6; end
        5'd3: begin op_a = sx16(pa[47:32]); op_b = b6; end
        5'd4: begin op_a = sx16(pb[15:0]); op_b = sq; end
        5'd5: begin op_a = {16'b0, pa[63:48]}; op_b = x3 + 32'd32768; end
        5'd6: begin op_a = up - b3; op_b = 32'd50000 >> oss; end
        5'd7: begin
          use_div = 1'b1;
          op_a = b7[31] ? b7 : (b7 << 1); op_b = b4;
        end
        5'd8: begin op_a = asr(p, 5'd8); op_b = asr(p, 5'd8); end
        5'd9: begin op_a = x1; op_b = 32'd3038; end
        default: begin op_a = 32'hFFFFE343; op_b = p; end
      endcase
    end
    mreq = '{start: (state == S_ISSUE) && !use_div, sgn: 1'b0, a: op_a, b: op_b};
    dreq = '{start: (state == S_ISSUE) && use_div, sgn: op_sgn, a: op_a, b: op_b};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      step <= '0;
      tc <= '0; pa <= '0; pb <= '0; oss <= 2'd3;
      tf <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.valid) begin
        case (cfg.data.idx)
          REG_TEMP: tc <= cfg.data.value;
          REG_PA: pa <= cfg.data.value;
          REG_PB: pb <= cfg.data.value[31:0];
          REG_OSS: oss <= cfg.data.value[1:0];
          default: ;
        endcase
      end
      if (load_out) out_valid <= 1'b1;
      else if (out_valid && out_ch.ready) out_valid <= 1'b0;
      case (state)
        S_IDLE: if (in_ch.valid) begin
          kind <= in_ch.data.action;
          raw <= in_ch.data.raw_value;
          b6 <= tf - 32'd4000;
          step <= '0;
          state <= S_ISSUE;
        end
        S_ISSUE: state <= S_WAIT;
        S_WAIT: if (!mbusy && !dbusy) begin
          state <= last_step ? S_OUT : S_ISSUE;
          step <= step + 5'd1;
          if (kind == KIND_TEMP) begin
            if (step == 5'd0) x1 <= asr(res, 5'd15);
            else begin
              tf <= ft;
              acc <= asr(ft + 32'd8, 5'd4);
            end
          end else begin
            case (step)
              5'd0: sq <= asr(res, 5'd12);
              5'd1: x1 <= asr(res, 5'd11);
              5'd2: begin
                x3 <= x1 + asr(res, 5'd11);
              end
              5'd3: begin
                b3 <= asr((((sx16(pa[15:0]) << 2) + x3) << oss) + 32'd2, 5'd2);
                x1 <= asr(res, 5'd13);
              end
              5'd4: x3 <= asr(x1 + asr(res, 5'd16) + 32'd2, 5'd2);
              5'd5: b4 <= res >> 15;
              5'd6: b7 <= res;
              5'd7: p <= b7[31] ? (res << 1) : res;
              5'd8: x1 <= res;
              5'd9: x1 <= asr(res, 5'd16);
              default: begin
                acc <= p + asr(x1 + asr(res, 5'd16) + 32'd3791, 5'd4);
              end
            endcase
          end
        end
        S_OUT: if (load_out) begin
          okind <= kind;
          ot <= (kind == KIND_TEMP) ? acc[TempW-1:0] : '0;
          op <= (kind == KIND_TEMP) ? '0 : acc;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid = out_valid;
  assign out_ch.data.result_kind = okind;
  assign out_ch.data.temperature_tenths = ot;
  assign out_ch.data.pressure_pa = op;

  `BSC_ASSERT(a_one_unit, clk, rst, !(mbusy && dbusy), "both units busy")
  `BSC_ASSERT(a_no_accept_busy, clk, rst, (state != S_IDLE) |-> !in_ch.ready, "accept while busy")
  `BSC_ASSERT(a_hold_out, clk, rst, (out_valid && !out_ch.ready) |=> out_valid, "result dropped")
endmodule
`default_nettype wire

@@ rtl/bsc_mul.sv @@
// Bit-serial 32x32 multiplier, low 32 bits of product, one bit per cycle.
// Depends on bsc_pkg.
`default_nettype none
module bsc_mul (
  input wire logic clk,
  input wire logic rst,
  input wire bsc_pkg::op_req_t req,
  output logic busy,
  output logic [bsc_pkg::WordW-1:0] prod
);
  import bsc_pkg::*;
  logic [WordW-1:0] mcand, mplier;
  logic [5:0] cnt;
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt <= 6'd0;
      mcand <= req.a;
      mplier <= req.b;
      prod <= '0;
    end else if (busy) begin
      if (mplier[0]) prod <= prod + mcand;
      mcand <= mcand << 1;
      mplier <= mplier >> 1;
      cnt <= cnt + 6'd1;
      if (cnt == 6'd31) busy <= 1'b0;
    end
  end
endmodule
`default_nettype wire

@@ rtl/bsc_div.sv @@
// Restoring divider, one quotient bit per cycle, signed or unsigned.
// Zero divisor gives all ones. Depends on bsc_pkg.
`default_nettype none
module bsc_div (
  input wire logic clk,
  input wire logic rst,
  input wire bsc_pkg::op_req_t req,
  output logic busy,
  output logic [bsc_pkg::WordW-1:0] quot
);
  import bsc_pkg::*;
  logic [WordW-1:0] num, den, rem;
  logic neg, dz;
  logic [5:0] cnt;
  logic [WordW:0] trial;
  logic [WordW-1:0] qn;
  assign trial = {rem, num[WordW-1]} - {1'b0, den};
  assign qn = {num[WordW-2:0], ~trial[WordW]};
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt <= '0;
    end else if (req.start) begin
      busy <= 1'b1;
      cnt <= '0;
      num <= (req.sgn && req.a[WordW-1]) ? -req.a : req.a;
      den <= (req.sgn && req.b[WordW-1]) ? -req.b : req.b;
      neg <= req.sgn && (req.a[WordW-1] ^ req.b[WordW-1]);
      dz <= (req.b == '0);
      rem <= '0;
    end else if (busy) begin
      rem <= trial[WordW] ? {rem[WordW-2:0], num[WordW-1]} : trial[WordW-1:0];
      num <= qn;
      cnt <= cnt + 6'd1;
      if (cnt == 6'd31) begin
        busy <= 1'b0;
        quot <= dz ? '1 : (neg ? -qn : qn);
      end
    end
  end
endmodule
`default_nettype wire

@@ tb/barometric_sensor_compensation_tb.sv @@
// Self-checking testbench for barometric_sensor_compensation.
// Depends on bsc_pkg, bsc_if and the block; predicts every result in
// 32-bit wrapping arithmetic and compares it with the block's output.
`timescale 1ns / 1ps
`default_nettype none
module barometric_sensor_compensation_tb;
  import bsc_pkg::*;

  typedef struct packed {
    logic action;
    logic [RawW-1:0] raw_value;
  } reading_t;

  typedef struct packed {
    logic result_kind;
    logic signed [TempW-1:0] temperature_tenths;
    logic signed [WordW-1:0] pressure_pa;
  } reading_out_t;

  typedef struct packed {
    logic [CfgIdxW-1:0] idx;
    logic [CfgDataW-1:0] value;
  } reg_write_t;

  localparam int unsigned CycleLimit = 4_000_000;
  localparam int unsigned SettleCycles = 700;

  logic clk;
  logic rst;

  bsc_if #(.payload_t(reading_t)) in_ch ();
  bsc_if #(.payload_t(reading_out_t)) out_ch ();
  bsc_if #(.payload_t(reg_write_t)) cfg ();

  barometric_sensor_compensation dut (
    .clk(clk),
    .rst(rst),
    .in_ch(in_ch),
    .out_ch(out_ch),
    .cfg(cfg)
  );

  // Predictor state: register copies and the stored temperature factor.
  logic [63:0] temp_coefs_q;
  logic [63:0] press_a_q;
  logic [31:0] press_b_q;
  logic [1:0] oss_q;
  logic [31:0] b5_q;

  reading_out_t expected_readings[$];
  int unsigned mismatches;
  int unsigned cycle_count;
  int unsigned hold_off_cycles;
  bit no_gaps;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] sra32(input logic [31:0] v, input int s);
    logic signed [31:0] t;
    t = $signed(v) >>> s;
    return t;
  endfunction

  function automatic logic [31:0] coef_u(input logic [63:0] r, input int pos);
    return {16'd0, r[pos*16 +: 16]};
  endfunction

  function automatic logic [31:0] coef_s(input logic [63:0] r, input int pos);
    logic [15:0] w;
    w = r[pos*16 +: 16];
    return {{16{w[15]}}, w};
  endfunction

  // Signed divide truncating toward zero; zero divisor gives all ones.
  function automatic logic [31:0] div_signed(input logic [31:0] n, input logic [31:0] d);
    logic [31:0] mn;
    logic [31:0] md;
    logic [31:0] q;
    if (d == 32'd0) return 32'hFFFF_FFFF;
    mn = n[31] ? 32'd0 - n : n;
    md = d[31] ? 32'd0 - d : d;
    q = mn / md;
    return (n[31] ^ d[31]) ? 32'd0 - q : q;
  endfunction

  function automatic logic [31:0] div_unsigned(input logic [31:0] n, input logic [31:0] d);
    if (d == 32'd0) return 32'hFFFF_FFFF;
    return n / d;
  endfunction

  function automatic reading_out_t compensate(input reading_t w);
    reading_out_t r;
    logic [31:0] ut, x1, x2, x3, t;
    logic [31:0] up, b6, sq, b3, b4, b7, p;
    r = '0;
    if (w.action == KIND_TEMP) begin
      ut = {16'd0, w.raw_value[15:0]};
      x1 = sra32((ut - coef_u(temp_coefs_q, 1)) * coef_u(temp_coefs_q, 0), 15);
      x2 = div_signed(coef_s(temp_coefs_q, 2) << 11, x1 + coef_s(temp_coefs_q, 3));
      b5_q = x1 + x2;
      t = sra32(b5_q + 32'd8, 4);
      r.result_kind = KIND_TEMP;
      r.temperature_tenths = t[TempW-1:0];
    end else begin
      up = {8'd0, w.raw_value} >> (4'd8 - oss_q);
      b6 = b5_q - 32'd4000;
      sq = sra32(b6 * b6, 12);
      x1 = sra32(coef_s({32'd0, press_b_q}, 1) * sq, 11);
      x2 = sra32(coef_s(press_a_q, 1) * b6, 11);
      x3 = x1 + x2;
      b3 = sra32(((coef_s(press_a_q, 0) * 32'd4 + x3) << oss_q) + 32'd2, 2);
      x1 = sra32(coef_s(press_a_q, 2) * b6, 13);
      x2 = sra32(coef_s({32'd0, press_b_q}, 0) * sq, 16);
      x3 = sra32(x1 + x2 + 32'd2, 2);
      b4 = (coef_u(press_a_q, 3) * (x3 + 32'd32768)) >> 15;
      b7 = (up - b3) * (32'd50000 >> oss_q);
      if (!b7[31]) p = div_unsigned(b7 << 1, b4);
      else p = div_unsigned(b7, b4) << 1;
      x1 = sra32(p, 8) * sra32(p, 8);
      x1 = sra32(x1 * 32'd3038, 16);
      x2 = sra32((32'd0 - 32'd7357) * p, 16);
      p = p + sra32(x1 + x2 + 32'd3791, 4);
      r.result_kind = KIND_PRESS;
      r.pressure_pa = p;
    end
    return r;
  endfunction

  // Check each accepted result word against the oldest prediction.
  always @(posedge clk) begin
    reading_out_t got, exp_r;
    if (!rst && out_ch.valid && out_ch.ready) begin
      got = out_ch.data;
      if (expected_readings.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: unexpected result word %h", got);
      end else begin
        exp_r = expected_readings.pop_front();
        if (got.result_kind !== exp_r.result_kind
            || got.temperature_tenths !== exp_r.temperature_tenths
            || got.pressure_pa !== exp_r.pressure_pa) begin
          mismatches++;
          if (mismatches <= 10)
            $display("ERROR: kind/temp/press expected %0d/%0d/%0d got %0d/%0d/%0d",
                     exp_r.result_kind, exp_r.temperature_tenths, exp_r.pressure_pa,
                     got.result_kind, got.temperature_tenths, got.pressure_pa);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // Result receiver: random gap per word, plus a long hold-off on request.
  initial begin
    int gap;
    out_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      out_ch.ready = 1'b0;
      gap = no_gaps ? 0 : $urandom_range(0, 7);
      repeat (gap) @(negedge clk);
      while (hold_off_cycles > 0) begin
        hold_off_cycles--;
        @(negedge clk);
      end
      out_ch.ready = 1'b1;
      do @(posedge clk); while (!out_ch.valid);
      @(negedge clk);
    end
  end

  task automatic send_reading(input logic action, input logic [RawW-1:0] raw,
                              input bit wait_gap = 1'b1);
    reading_t w;
    int gap;
    gap = (wait_gap && !no_gaps) ? $urandom_range(0, 7) : 0;
    repeat (gap) @(negedge clk);
    w.action = action;
    w.raw_value = raw;
    in_ch.data = w;
    in_ch.valid = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    expected_readings.push_back(compensate(w));
    @(negedge clk);
    in_ch.valid = 1'b0;
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [63:0] value);
    cfg.data = '{idx: idx, value: value};
    cfg.valid = 1'b1;
    do @(posedge clk); while (!cfg.ready);
    case (idx)
      REG_TEMP: temp_coefs_q = value;
      REG_PA: press_a_q = value;
      REG_PB: press_b_q = value[31:0];
      REG_OSS: oss_q = value[1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg.valid = 1'b0;
  endtask

  task automatic drain();
    while (expected_readings.size() != 0) @(negedge clk);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Calibration set close to a real part, with optional jitter.
  task automatic load_typical(input bit jitter);
    logic [15:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    ac1 = 16'd408; ac2 = -16'sd72; ac3 = -16'sd14383; ac4 = 16'd32741;
    ac5 = 16'd32757; ac6 = 16'd23153; b1 = 16'd6190; b2 = 16'd4;
    mc = -16'sd8711; md = 16'd2868;
    if (jitter) begin
      ac1 += 16'($urandom_range(0, 400)) - 16'd200;
      ac2 += 16'($urandom_range(0, 100)) - 16'd50;
      ac3 += 16'($urandom_range(0, 2000)) - 16'd1000;
      ac4 += 16'($urandom_range(0, 2000)) - 16'd1000;
      ac5 += 16'($urandom_range(0, 4000)) - 16'd2000;
      ac6 += 16'($urandom_range(0, 4000)) - 16'd2000;
      b1 += 16'($urandom_range(0, 400)) - 16'd200;
      b2 += 16'($urandom_range(0, 20)) - 16'd10;
      mc += 16'($urandom_range(0, 1000)) - 16'd500;
      md += 16'($urandom_range(0, 400)) - 16'd200;
    end
    write_reg(REG_TEMP, {md, mc, ac6, ac5});
    write_reg(REG_PA, {ac4, ac3, ac2, ac1});
    write_reg(REG_PB, {32'd0, b2, b1});
    write_reg(REG_OSS, 64'($urandom_range(0, 3)));
  endtask

  task automatic test_reset_state();
    // Pressure before any temperature uses a zero factor and reset registers.
    send_reading(KIND_PRESS, 24'h000000);
    send_reading(KIND_PRESS, 24'hFFFFFF);
    // All-zero coefficients also give a zero temperature divisor.
    send_reading(KIND_TEMP, 24'h00FFFF);
    drain();
  endtask

  task automatic test_directed();
    load_typical(1'b0);
    write_reg(REG_OSS, 64'd0);
    send_reading(KIND_TEMP, 24'd27898);
    send_reading(KIND_PRESS, 24'd23843 << 8);
    send_reading(KIND_TEMP, 24'h000000);
    send_reading(KIND_PRESS, 24'h000000);
    send_reading(KIND_TEMP, 24'hFF0000);
    send_reading(KIND_PRESS, 24'hFFFFFF);
    drain();
    write_reg(REG_OSS, 64'd3);
    send_reading(KIND_TEMP, 24'h00FFFF);
    send_reading(KIND_PRESS, 24'hFFFFFF);
    send_reading(KIND_PRESS, 24'h800000);
    drain();
    // Extremes: every coefficient bit set, then ac5 and md cleared for a zero divisor.
    write_reg(REG_TEMP, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_PA, 64'hFFFF_FFFF_FFFF_FFFF);
    write_reg(REG_PB, 64'hFFFF_FFFF);
    send_reading(KIND_TEMP, 24'h00FFFF);
    send_reading(KIND_PRESS, 24'hFFFFFF);
    send_reading(KIND_TEMP, 24'h000000);
    send_reading(KIND_PRESS, 24'h123456);
    drain();
    write_reg(REG_TEMP, {16'd0, 16'h8000, 16'd0, 16'd0});
    write_reg(REG_PA, 64'h0000_0000_0000_0000);
    send_reading(KIND_TEMP, 24'h001234);
    send_reading(KIND_PRESS, 24'h654321);
    drain();
    write_reg(REG_OSS, 64'd1);
  endtask

  task automatic test_backpressure();
    load_typical(1'b1);
    hold_off_cycles = 3000;
    for (int i = 0; i < 12; i++)
      send_reading(i[0], 24'($urandom), 1'b0);
    drain();
    // Pause the sender until every result is back, then resume.
    send_reading(KIND_TEMP, 24'($urandom));
    drain();
    send_reading(KIND_PRESS, 24'($urandom));
    drain();
  endtask

  task automatic test_random();
    int n;
    for (int phase = 0; phase < 10; phase++) begin
      case ($urandom_range(0, 3))
        0: load_typical(1'b0);
        1, 2: load_typical(1'b1);
        default: begin
          write_reg(REG_TEMP, {$urandom, $urandom});
          write_reg(REG_PA, {$urandom, $urandom});
          write_reg(REG_PB, {32'd0, $urandom});
          write_reg(REG_OSS, 64'($urandom_range(0, 3)));
        end
      endcase
      no_gaps = (phase % 4 == 3);
      n = 0;
      while (n < 100) begin
        if ($urandom_range(0, 9) < 8) begin
          // Well-formed pair: temperature, mostly near its typical range, then pressure.
          send_reading(KIND_TEMP, $urandom_range(0, 3) == 0 ? 24'($urandom)
                                                           : 24'($urandom_range(20000, 36000)));
          send_reading(KIND_PRESS, 24'($urandom));
          n += 2;
        end else begin
          send_reading(1'($urandom), 24'($urandom));
          n++;
        end
      end
      no_gaps = 1'b0;
      drain();
    end
  endtask

  initial begin
    rst = 1'b1;
    in_ch.valid = 1'b0;
    in_ch.data = '0;
    cfg.valid = 1'b0;
    cfg.data = '0;
    mismatches = 0;
    cycle_count = 0;
    hold_off_cycles = 0;
    no_gaps = 1'b0;
    temp_coefs_q = '0;
    press_a_q = '0;
    press_b_q = '0;
    oss_q = 2'd3;
    b5_q = '0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_reset_state();
    test_directed();
    test_backpressure();
    test_random();
    drain();

    if (mismatches == 0 && expected_readings.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end
endmodule
`default_nettype wire
